>>> design/cngr_pkg.sv
package cngr_pkg;

	// Display and glyph geometry
	localparam int DISPLAY_WIDTH = 32;
	localparam int GLYPH_WIDTH   = 5;
	localparam int GLYPH_HEIGHT  = 7;

	localparam int DIGIT_COUNT  = 10;
	localparam int NUMBER_LIMIT = 1000;
	localparam int FONT_DEPTH   = DIGIT_COUNT * GLYPH_HEIGHT;
	localparam int ADDR_W       = $clog2(FONT_DEPTH);
	localparam int ROW_W        = $clog2(GLYPH_HEIGHT);
	localparam int PITCH        = GLYPH_WIDTH + 1;
	localparam int LINE_W       = DISPLAY_WIDTH + 3 * PITCH;

	// Reciprocal multipliers for the decimal split of values below 1024
	localparam int HUND_MUL = 41;
	localparam int HUND_SH  = 12;
	localparam int TEN_MUL  = 103;
	localparam int TEN_SH   = 10;

	// Item opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// Digit count codes
	localparam logic [1:0] NDIG_ONE   = 2'd1;
	localparam logic [1:0] NDIG_TWO   = 2'd2;
	localparam logic [1:0] NDIG_THREE = 2'd3;

	// Left padding of the joined row for a given digit count
	function automatic int pad_for(input int n);
		int joined;
		joined = PITCH * n;
		return (joined <= DISPLAY_WIDTH) ? ((DISPLAY_WIDTH - joined) >> 1) : 0;
	endfunction

	localparam int PAD1 = pad_for(1);
	localparam int PAD2 = pad_for(2);
	localparam int PAD3 = pad_for(3);

	localparam logic [31:0] VIS_MASK = (DISPLAY_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << DISPLAY_WIDTH) - 64'd1);

	typedef logic [3:0]             digit_t;
	typedef logic [ROW_W-1:0]       grow_t;
	typedef logic [GLYPH_WIDTH-1:0] glyph_t;
	typedef logic [ADDR_W-1:0]      faddr_t;

	// After the first split
	typedef struct packed {
		logic       opcode;
		digit_t     glyph_digit;
		logic [2:0] glyph_row;
		logic [4:0] glyph_bits;
		grow_t      row;
		logic       too_big;
		logic [1:0] ndig;
		digit_t     hund;
		logic [6:0] rem;
	} s2_t;

	// All three digits known
	typedef struct packed {
		logic       opcode;
		digit_t     glyph_digit;
		logic [2:0] glyph_row;
		logic [4:0] glyph_bits;
		grow_t      row;
		logic       too_big;
		logic [1:0] ndig;
		digit_t     hund;
		digit_t     tens;
		digit_t     units;
	} s3_t;

	// Glyph rows fetched
	typedef struct packed {
		grow_t      row;
		logic       too_big;
		logic [1:0] ndig;
		glyph_t     hund_g;
		glyph_t     tens_g;
		glyph_t     units_g;
	} s4_t;

	function automatic faddr_t font_addr(input digit_t d, input grow_t r);
		return faddr_t'(ADDR_W'(d) * ADDR_W'(GLYPH_HEIGHT) + ADDR_W'(r));
	endfunction

endpackage

>>> design/cngr_in_if.sv
interface cngr_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [3:0] glyph_digit;
	logic [2:0] glyph_row;
	logic [4:0] glyph_bits;
	logic [9:0] number;

	modport source (output valid, output opcode, output glyph_digit, output glyph_row,
		output glyph_bits, output number, input ready);
	modport sink (input valid, input opcode, input glyph_digit, input glyph_row,
		input glyph_bits, input number, output ready);
endinterface

>>> design/cngr_out_if.sv
interface cngr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  row_index;
	logic [31:0] row_pixels;
	logic        last_row;
	logic        out_of_range;

	modport source (output valid, output row_index, output row_pixels, output last_row,
		output out_of_range, input ready);
	modport sink (input valid, input row_index, input row_pixels, input last_row,
		input out_of_range, output ready);
endinterface

>>> design/centered_number_glyph_renderer_unit.sv
// Centred number glyph renderer.
// Items arrive on cmd (valid/ready). A load item (opcode 0) writes one glyph row
// of one digit into the font store and gives no result. A render item (opcode 1)
// gives GLYPH_HEIGHT results on disp, one per display row, top row first, with
// last_row set on the final one and out_of_range set (blank pixels) for 1000 up.
// The first row of a render passes through the s1 to s5 registers to disp;
// later rows follow one per cycle while disp is not stalled.
// The front stage walks a render through its rows one per cycle while disp does
// not stall, holding cmd until the last row issues; a load leaves after one issue.
// The next item is taken in the cycle the previous one issues its last row.
// Five register stages sit between cmd and disp. When disp stalls, every stage
// holds its item and nothing is lost or repeated; cmd stays ready only while
// the front stage has room.
// Reset clears all valid bits and the row counter. The font store is not
// cleared: a glyph row must be loaded before any render uses it.
module centered_number_glyph_renderer_unit (
	input  logic       clk,
	input  logic       arst_n,
	cngr_in_if.sink    cmd,
	cngr_out_if.source disp
);
	import cngr_pkg::*;

	logic adv;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	s2_t  data_s2;
	s3_t  data_s3;
	s4_t  data_s4;

	// Advance the whole pipeline unless the output register is stuck
	assign adv = !disp.valid || disp.ready;

	cngr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cmd      (cmd),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	cngr_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	cngr_font u_font (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	cngr_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4),
		.disp     (disp)
	);

	// Rows of one frame follow each other without a gap once taken
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && !disp.last_row |=>
			disp.valid && disp.row_index == 3'($past(disp.row_index) + 3'd1) &&
			disp.out_of_range == $past(disp.out_of_range))
		else $error("frame rows out of order");

	// A new frame starts at the top row
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && disp.last_row |=>
			!disp.valid || disp.row_index == 3'd0)
		else $error("frame does not start at row zero");

	// Out-of-range rows are blank
	a_blank_rows: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.out_of_range |-> disp.row_pixels == 32'd0)
		else $error("out-of-range row not blank");

	// No item is taken into a full front stage while the pipeline is stalled
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv |-> !cmd.ready || !u_seq.valid_s1)
		else $error("item taken while front stage stalled");

endmodule

>>> design/cngr_seq.sv
module cngr_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	cngr_in_if.sink       cmd,
	output logic          valid_s2,
	output cngr_pkg::s2_t data_s2
);
	import cngr_pkg::*;

	logic       valid_s1;
	logic       opcode_s1;
	digit_t     glyph_digit_s1;
	logic [2:0] glyph_row_s1;
	logic [4:0] glyph_bits_s1;
	logic [9:0] number_s1;
	grow_t      row_q;

	logic       done;
	logic       take;
	logic [15:0] hund_prod;
	digit_t     hund;
	s2_t        nxt;

	// A load leaves after one issue, a render after its last row
	assign done = (opcode_s1 == OP_LOAD) || (row_q == grow_t'(GLYPH_HEIGHT - 1));
	assign cmd.ready = !valid_s1 || (adv && done);
	assign take = cmd.valid && cmd.ready;

	// Hold the item and step through its rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_q    <= '0;
		end else if (take) begin
			valid_s1 <= 1'b1;
			row_q    <= '0;
		end else if (adv && valid_s1) begin
			if (done) begin
				valid_s1 <= 1'b0;
			end else begin
				row_q <= row_q + grow_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1      <= cmd.opcode;
			glyph_digit_s1 <= cmd.glyph_digit;
			glyph_row_s1   <= cmd.glyph_row;
			glyph_bits_s1  <= cmd.glyph_bits;
			number_s1      <= cmd.number;
		end
	end

	// Split off the hundreds digit
	assign hund_prod = 16'(number_s1) * 16'(HUND_MUL);
	assign hund      = digit_t'(hund_prod >> HUND_SH);

	always_comb begin
		nxt.opcode      = opcode_s1;
		nxt.glyph_digit = glyph_digit_s1;
		nxt.glyph_row   = glyph_row_s1;
		nxt.glyph_bits  = glyph_bits_s1;
		nxt.row         = row_q;
		nxt.too_big     = number_s1 >= 10'(NUMBER_LIMIT);
		nxt.hund        = hund;
		nxt.rem         = 7'(number_s1 - 10'(10'(hund) * 10'd100));
		if (number_s1 >= 10'd100) begin
			nxt.ndig = NDIG_THREE;
		end else if (number_s1 >= 10'd10) begin
			nxt.ndig = NDIG_TWO;
		end else begin
			nxt.ndig = NDIG_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

>>> design/cngr_digits.sv
module cngr_digits (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid_s2,
	input  cngr_pkg::s2_t data_s2,
	output logic          valid_s3,
	output cngr_pkg::s3_t data_s3
);
	import cngr_pkg::*;

	logic [13:0] tens_prod;
	digit_t      tens;
	digit_t      units;
	s3_t         nxt;

	// Split the remainder into tens and units
	assign tens_prod = 14'(data_s2.rem) * 14'(TEN_MUL);
	assign tens      = digit_t'(tens_prod >> TEN_SH);
	assign units     = digit_t'(data_s2.rem - 7'(7'(tens) * 7'd10));

	always_comb begin
		nxt.opcode      = data_s2.opcode;
		nxt.glyph_digit = data_s2.glyph_digit;
		nxt.glyph_row   = data_s2.glyph_row;
		nxt.glyph_bits  = data_s2.glyph_bits;
		nxt.row         = data_s2.row;
		nxt.too_big     = data_s2.too_big;
		nxt.ndig        = data_s2.ndig;
		// park the fetches on digit zero for blank rows
		if (data_s2.too_big) begin
			nxt.hund  = '0;
			nxt.tens  = '0;
			nxt.units = '0;
		end else begin
			nxt.hund  = data_s2.hund;
			nxt.tens  = tens;
			nxt.units = units;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			data_s3 <= nxt;
		end
	end

endmodule

>>> design/cngr_font.sv
module cngr_font (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid_s3,
	input  cngr_pkg::s3_t data_s3,
	output logic          valid_s4,
	output cngr_pkg::s4_t data_s4
);
	import cngr_pkg::*;

	// One copy of the font per digit position, so a row reads all three at once
	glyph_t font_h_q [FONT_DEPTH];
	glyph_t font_t_q [FONT_DEPTH];
	glyph_t font_u_q [FONT_DEPTH];

	glyph_t     hund_g_s4;
	glyph_t     tens_g_s4;
	glyph_t     units_g_s4;
	grow_t      row_s4;
	logic       too_big_s4;
	logic [1:0] ndig_s4;

	logic   wr_en;
	faddr_t wr_addr;
	glyph_t wr_data;
	logic   is_render;

	assign is_render = data_s3.opcode == OP_RENDER;
	assign wr_en = adv && valid_s3 && !is_render &&
		(data_s3.glyph_digit < digit_t'(DIGIT_COUNT)) &&
		(int'(data_s3.glyph_row) < GLYPH_HEIGHT);
	assign wr_addr = font_addr(data_s3.glyph_digit, grow_t'(data_s3.glyph_row));
	assign wr_data = glyph_t'(data_s3.glyph_bits);

	// Write all copies in item order with the reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			font_h_q[wr_addr] <= wr_data;
			font_t_q[wr_addr] <= wr_data;
			font_u_q[wr_addr] <= wr_data;
		end
	end

	// Registered reads, held on stall
	always_ff @(posedge clk) begin
		if (adv && valid_s3 && is_render) begin
			hund_g_s4  <= font_h_q[font_addr(data_s3.hund, data_s3.row)];
			tens_g_s4  <= font_t_q[font_addr(data_s3.tens, data_s3.row)];
			units_g_s4 <= font_u_q[font_addr(data_s3.units, data_s3.row)];
			row_s4     <= data_s3.row;
			too_big_s4 <= data_s3.too_big;
			ndig_s4    <= data_s3.ndig;
		end
	end

	// Drop load items here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3 && is_render;
		end
	end

	assign data_s4 = '{row: row_s4, too_big: too_big_s4, ndig: ndig_s4,
		hund_g: hund_g_s4, tens_g: tens_g_s4, units_g: units_g_s4};

endmodule

>>> design/cngr_row.sv
module cngr_row (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid_s4,
	input  cngr_pkg::s4_t data_s4,
	cngr_out_if.source    disp
);
	import cngr_pkg::*;

	logic              valid_s5;
	logic [2:0]        row_index_s5;
	logic [31:0]       row_pixels_s5;
	logic              last_row_s5;
	logic              out_of_range_s5;

	logic [LINE_W-1:0] h_w;
	logic [LINE_W-1:0] t_w;
	logic [LINE_W-1:0] u_w;
	logic [LINE_W-1:0] line;
	logic [31:0]       pixels;

	assign h_w = LINE_W'(data_s4.hund_g);
	assign t_w = LINE_W'(data_s4.tens_g);
	assign u_w = LINE_W'(data_s4.units_g);

	// Place the glyph rows at the centred offsets for this digit count
	always_comb begin
		case (data_s4.ndig)
			NDIG_ONE:   line = u_w << PAD1;
			NDIG_TWO:   line = (t_w << PAD2) | (u_w << (PAD2 + PITCH));
			NDIG_THREE: line = (h_w << PAD3) | (t_w << (PAD3 + PITCH)) |
				(u_w << (PAD3 + 2 * PITCH));
			default:    line = '0;
		endcase
	end

	assign pixels = data_s4.too_big ? 32'd0 : (32'(line) & VIS_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s4) begin
			row_index_s5    <= 3'(data_s4.row);
			row_pixels_s5   <= pixels;
			last_row_s5     <= data_s4.row == grow_t'(GLYPH_HEIGHT - 1);
			out_of_range_s5 <= data_s4.too_big;
		end
	end

	assign disp.valid        = valid_s5;
	assign disp.row_index    = row_index_s5;
	assign disp.row_pixels   = row_pixels_s5;
	assign disp.last_row     = last_row_s5;
	assign disp.out_of_range = out_of_range_s5;

endmodule
